// ===== hw/rtl/lpps_pkg.sv =====
// Shared constants, types and the built-in chase pattern for the LED pattern PWM sequencer.
// No dependencies; the interfaces and the sequencer refer to it by scoped names, the testbench files import it.

package lpps_pkg;

  localparam int ROWS       = 32;
  localparam int LEDS       = 16;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int LED_W      = $clog2(LEDS);
  localparam int LVL_W      = 8;
  localparam int ROW_DW     = LEDS * LVL_W;
  localparam int FUNC_W     = 2;
  localparam int SMP_W      = 10;
  localparam int STEP_W     = 16;
  localparam int PWM_W      = 8;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = STEP_W + SMP_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W);

  localparam logic [PWM_W-1:0]  PWM_PERIOD_RST = PWM_W'(100);
  localparam logic [STEP_W-1:0] INIT_LIMIT_RST = STEP_W'(1000);
  localparam logic [STEP_W-1:0] LIMIT_ZERO_RST = STEP_W'(4000);
  localparam logic [STEP_W-1:0] SLOPE_RST      = STEP_W'(3);
  localparam logic [STEP_W-1:0] SPAN_RST       = STEP_W'(1);
  localparam logic [PWM_W-1:0]  PWM_CNT_RST    = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 2'd0,
    FN_SAMPLE = 2'd1,
    FN_WRITE  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_PERIOD = 3'd0,
    CFG_INIT_LIMIT = 3'd1,
    CFG_LIMIT_ZERO = 3'd2,
    CFG_SLOPE      = 3'd3,
    CFG_SPAN       = 3'd4
  } cfg_idx_t;

  // Lane 0 sits at the most significant byte, so literals read left to right by LED.
  typedef logic [0:LEDS-1][LVL_W-1:0] row_t;

  // Power-up contents of the pattern memory, one row at a time.
  function automatic row_t chase_row(input logic [ROW_W-1:0] r);
    row_t v;
    case (r)
      5'd0:    v = 128'h0000_641e_0602_0000_0000_0000_0000_0000;
      5'd1:    v = 128'h0064_1e06_0200_0000_0000_0000_0000_0000;
      5'd2:    v = 128'h641e_0602_0000_0000_0000_0000_0000_0000;
      5'd3:    v = 128'h3206_0200_0000_0000_0000_0000_0000_0000;
      5'd4:    v = 128'h1e64_0000_0000_0000_0000_0000_0000_0000;
      5'd5:    v = 128'h061e_6400_0000_0000_0000_0000_0000_0000;
      5'd6:    v = 128'h0206_1e64_0000_0000_0000_0000_0000_0000;
      5'd7:    v = 128'h0002_061e_6400_0000_0000_0000_0000_0000;
      5'd8:    v = 128'h0000_0206_1e64_0000_0000_0000_0000_0000;
      5'd9:    v = 128'h0000_0002_061e_6400_0000_0000_0000_0000;
      5'd10:   v = 128'h0000_0000_0206_1e64_0000_0000_0000_0000;
      5'd11:   v = 128'h0000_0000_0002_061e_6400_0000_0000_0000;
      5'd12:   v = 128'h0000_0000_0000_0206_1e64_0000_0000_0000;
      5'd13:   v = 128'h0000_0000_0000_0002_061e_6400_0000_0000;
      5'd14:   v = 128'h0000_0000_0000_0000_0206_1e64_0000_0000;
      5'd15:   v = 128'h0000_0000_0000_0000_0002_061e_6400_0000;
      5'd16:   v = 128'h0000_0000_0000_0000_0000_0206_1e64_0000;
      5'd17:   v = 128'h0000_0000_0000_0000_0000_0002_061e_6400;
      5'd18:   v = 128'h0000_0000_0000_0000_0000_0000_0206_1e64;
      5'd19:   v = 128'h0000_0000_0000_0000_0000_0000_0002_0632;
      5'd20:   v = 128'h0000_0000_0000_0000_0000_0000_0000_641e;
      5'd21:   v = 128'h0000_0000_0000_0000_0000_0000_0064_1e06;
      5'd22:   v = 128'h0000_0000_0000_0000_0000_0000_641e_0602;
      5'd23:   v = 128'h0000_0000_0000_0000_0000_0064_1e06_0200;
      5'd24:   v = 128'h0000_0000_0000_0000_0000_641e_0602_0000;
      5'd25:   v = 128'h0000_0000_0000_0000_0064_1e06_0200_0000;
      5'd26:   v = 128'h0000_0000_0000_0000_641e_0602_0000_0000;
      5'd27:   v = 128'h0000_0000_0000_0064_1e06_0200_0000_0000;
      5'd28:   v = 128'h0000_0000_0000_641e_0602_0000_0000_0000;
      5'd29:   v = 128'h0000_0000_0064_1e06_0200_0000_0000_0000;
      5'd30:   v = 128'h0000_0000_641e_0602_0000_0000_0000_0000;
      5'd31:   v = 128'h0000_0064_1e06_0200_0000_0000_0000_0000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/lpps_ifs.sv =====
// Valid/ready channel interfaces for the sequencer: command items in, tick results out.
// Depends on lpps_pkg for field widths.

interface lpps_in_if;
  logic                         valid;
  logic                         ready;
  logic [lpps_pkg::FUNC_W-1:0]  func;
  logic [lpps_pkg::SMP_W-1:0]   sample;
  logic [lpps_pkg::ROW_W-1:0]   row;
  logic [lpps_pkg::LED_W-1:0]   led;
  logic [lpps_pkg::LVL_W-1:0]   level;

  modport source (output valid, func, sample, row, led, level, input ready);
  modport sink   (input valid, func, sample, row, led, level, output ready);
endinterface

interface lpps_out_if;
  logic                         valid;
  logic                         ready;
  logic [lpps_pkg::MASK_W-1:0]  led_mask;
  logic                         start_conversion;
  logic [lpps_pkg::ROW_W-1:0]   row_index;

  modport source (output valid, led_mask, start_conversion, row_index, input ready);
  modport sink   (input valid, led_mask, start_conversion, row_index, output ready);
endinterface

// ===== hw/rtl/lpps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.

module lpps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/led_pattern_pwm_sequencer.sv =====
// Top level of the LED pattern PWM sequencer: control FSM, PWM lanes, step-limit divider.
// Depends on lpps_pkg, lpps_ifs (lpps_in_if, lpps_out_if) and lpps_ram.
//
//   port       dir  kind                      payload
//   in_ch      in   valid/ready, lpps_in_if   func, sample, row, led, level
//   out_ch     out  valid/ready, lpps_out_if  led_mask, start_conversion, row_index
//   cfg_*      in   write enable, no ready    cfg_index (3 b), cfg_wdata (16 b)
//
// Tick: accepted in idle while the pattern row is read, then committed to the output register in S_TICK.
// Pattern write: row read on accept, then modified row written back in S_WRITE.
// Analog sample: runs the bit-per-cycle 26-bit restoring divider, then sets the step limit in S_LIMIT.
// Synchronous active-low reset; no clearing pass, rows never written read as the chase pattern.
// A tick result waits in the output register; the next item is taken meanwhile, and a
// following tick holds in S_TICK until that register is free.

module led_pattern_pwm_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  lpps_in_if.sink                          in_ch,
  lpps_out_if.source                       out_ch,
  input  logic                             cfg_wr_en,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_WRITE,
    S_DIV,
    S_LIMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [lpps_pkg::PWM_W-1:0]  cfg_period_r;
  logic [lpps_pkg::STEP_W-1:0] cfg_init_lim_r;
  logic [lpps_pkg::STEP_W-1:0] cfg_lim_zero_r;
  logic [lpps_pkg::STEP_W-1:0] cfg_slope_r;
  logic [lpps_pkg::STEP_W-1:0] cfg_span_r;

  // sequencer state
  logic [lpps_pkg::ROW_W-1:0]  row_r;
  logic [lpps_pkg::STEP_W-1:0] step_cnt_r;
  logic [lpps_pkg::PWM_W-1:0]  pwm_cnt_r;
  logic [lpps_pkg::STEP_W-1:0] step_lim_r;
  logic                        lim_from_smp_r;
  lpps_pkg::row_t              levels_r;
  logic [lpps_pkg::ROWS-1:0]   row_vld_r;
  logic                        start_r;
  logic                        reload_r;

  // pattern write
  logic [lpps_pkg::ROW_W-1:0]  wr_row_r;
  logic [lpps_pkg::LED_W-1:0]  wr_led_r;
  logic [lpps_pkg::LVL_W-1:0]  wr_lvl_r;

  // divider
  logic [lpps_pkg::PROD_W-1:0]    quot_r;
  logic [lpps_pkg::STEP_W-1:0]    rem_r;
  logic [lpps_pkg::DIV_CNT_W-1:0] div_cnt_r;

  // output register
  logic                        out_vld_r;
  logic [lpps_pkg::MASK_W-1:0] out_mask_r;
  logic                        out_start_r;
  logic [lpps_pkg::ROW_W-1:0]  out_row_r;

  logic                        in_fire;
  logic [lpps_pkg::STEP_W-1:0] limit;
  logic                        advance;
  logic [lpps_pkg::ROW_W-1:0]  row_inc;
  logic [lpps_pkg::ROW_W-1:0]  row_nxt;
  logic [lpps_pkg::STEP_W-1:0] step_cnt_nxt;
  logic                        reload_nxt;
  logic [lpps_pkg::PWM_W-1:0]  pwm_cnt_nxt;

  logic                        ram_we;
  logic                        ram_re;
  logic [lpps_pkg::ROW_W-1:0]  ram_raddr;
  logic [lpps_pkg::ROW_DW-1:0] ram_rdata;
  logic [lpps_pkg::ROW_W-1:0]  rd_row;
  lpps_pkg::row_t              row_data;
  lpps_pkg::row_t              wr_data;
  lpps_pkg::row_t              lane_src;
  lpps_pkg::row_t              levels_nxt;
  logic [lpps_pkg::MASK_W-1:0] mask_c;
  logic                        tick_commit;

  logic [lpps_pkg::STEP_W:0]   rem_sh;
  logic                        q_bit;
  logic                        drop_ge;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid            = out_vld_r;
  assign out_ch.led_mask         = out_mask_r;
  assign out_ch.start_conversion = out_start_r;
  assign out_ch.row_index        = out_row_r;

  // step and PWM bookkeeping is done at the transfer of a tick
  assign limit        = lim_from_smp_r ? step_lim_r : cfg_init_lim_r;
  assign advance      = (step_cnt_r >= limit);
  assign row_inc      = (row_r == lpps_pkg::ROW_W'(lpps_pkg::ROWS - 1)) ? '0 : row_r + 1'b1;
  assign row_nxt      = advance ? row_inc : row_r;
  assign step_cnt_nxt = advance ? lpps_pkg::STEP_W'(1) : step_cnt_r + 1'b1;
  assign reload_nxt   = (pwm_cnt_r >= cfg_period_r);
  assign pwm_cnt_nxt  = reload_nxt ? lpps_pkg::PWM_W'(1) : pwm_cnt_r + 1'b1;

  assign ram_re    = in_fire && ((in_ch.func == lpps_pkg::FN_TICK) ||
                                 (in_ch.func == lpps_pkg::FN_WRITE));
  assign ram_raddr = (in_ch.func == lpps_pkg::FN_WRITE) ? in_ch.row : row_nxt;
  assign ram_we    = (state_r == S_WRITE);

  // rows never written still hold the power-up pattern
  assign rd_row   = (state_r == S_WRITE) ? wr_row_r : row_r;
  assign row_data = row_vld_r[rd_row] ? lpps_pkg::row_t'(ram_rdata)
                                      : lpps_pkg::chase_row(rd_row);

  always_comb begin
    wr_data           = row_data;
    wr_data[wr_led_r] = wr_lvl_r;
  end

  always_comb begin
    lane_src = reload_r ? row_data : levels_r;
    mask_c   = '0;
    for (int i = 0; i < lpps_pkg::LEDS; i++) begin
      mask_c[i]     = (lane_src[i] != '0);
      levels_nxt[i] = lane_src[i] - lpps_pkg::LVL_W'(mask_c[i]);
    end
  end

  assign tick_commit = (state_r == S_TICK) && (!out_vld_r || out_ch.ready);

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_r, quot_r[lpps_pkg::PROD_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, cfg_span_r});
  assign drop_ge = (quot_r >= lpps_pkg::PROD_W'(cfg_lim_zero_r));

  lpps_ram #(
    .WIDTH (lpps_pkg::ROW_DW),
    .DEPTH (lpps_pkg::ROWS)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_row_r),
    .wdata (wr_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_period_r   <= lpps_pkg::PWM_PERIOD_RST;
      cfg_init_lim_r <= lpps_pkg::INIT_LIMIT_RST;
      cfg_lim_zero_r <= lpps_pkg::LIMIT_ZERO_RST;
      cfg_slope_r    <= lpps_pkg::SLOPE_RST;
      cfg_span_r     <= lpps_pkg::SPAN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lpps_pkg::CFG_PWM_PERIOD: cfg_period_r   <= cfg_wdata[lpps_pkg::PWM_W-1:0];
        lpps_pkg::CFG_INIT_LIMIT: cfg_init_lim_r <= cfg_wdata[lpps_pkg::STEP_W-1:0];
        lpps_pkg::CFG_LIMIT_ZERO: cfg_lim_zero_r <= cfg_wdata[lpps_pkg::STEP_W-1:0];
        lpps_pkg::CFG_SLOPE:      cfg_slope_r    <= cfg_wdata[lpps_pkg::STEP_W-1:0];
        lpps_pkg::CFG_SPAN:       cfg_span_r     <= cfg_wdata[lpps_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      row_r          <= '0;
      step_cnt_r     <= '0;
      pwm_cnt_r      <= lpps_pkg::PWM_CNT_RST;
      step_lim_r     <= '0;
      lim_from_smp_r <= 1'b0;
      levels_r       <= '0;
      row_vld_r      <= '0;
      start_r        <= 1'b0;
      reload_r       <= 1'b0;
      div_cnt_r      <= '0;
      out_vld_r      <= 1'b0;
    end else begin
      // a tick completing on this edge refills the register instead
      if (out_vld_r && out_ch.ready && !tick_commit) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.func)
              lpps_pkg::FN_TICK: begin
                row_r      <= row_nxt;
                step_cnt_r <= step_cnt_nxt;
                pwm_cnt_r  <= pwm_cnt_nxt;
                start_r    <= advance;
                reload_r   <= reload_nxt;
                state_r    <= S_TICK;
              end
              lpps_pkg::FN_SAMPLE: begin
                // a zero span leaves the limit alone
                if (cfg_span_r != '0) begin
                  quot_r    <= lpps_pkg::PROD_W'(cfg_slope_r) *
                               lpps_pkg::PROD_W'(in_ch.sample);
                  rem_r     <= '0;
                  div_cnt_r <= lpps_pkg::DIV_CNT_W'(lpps_pkg::PROD_W - 1);
                  state_r   <= S_DIV;
                end
              end
              lpps_pkg::FN_WRITE: begin
                wr_row_r <= in_ch.row;
                wr_led_r <= in_ch.led;
                wr_lvl_r <= in_ch.level;
                state_r  <= S_WRITE;
              end
              default: ;
            endcase
          end
        end
        S_TICK: begin
          if (tick_commit) begin
            levels_r    <= levels_nxt;
            out_vld_r   <= 1'b1;
            out_mask_r  <= mask_c;
            out_start_r <= start_r;
            out_row_r   <= row_r;
            state_r     <= S_IDLE;
          end
        end
        S_WRITE: begin
          row_vld_r[wr_row_r] <= 1'b1;
          state_r             <= S_IDLE;
        end
        S_DIV: begin
          rem_r  <= q_bit ? lpps_pkg::STEP_W'(rem_sh - {1'b0, cfg_span_r})
                          : rem_sh[lpps_pkg::STEP_W-1:0];
          quot_r <= {quot_r[lpps_pkg::PROD_W-2:0], q_bit};
          if (div_cnt_r == '0) begin
            state_r <= S_LIMIT;
          end else begin
            div_cnt_r <= div_cnt_r - 1'b1;
          end
        end
        S_LIMIT: begin
          // clamp at zero when the slope term exceeds the zero-input limit
          step_lim_r     <= drop_ge ? '0
                                    : cfg_lim_zero_r - quot_r[lpps_pkg::STEP_W-1:0];
          lim_from_smp_r <= 1'b1;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ram_wr_only_in_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_WRITE))
    else $error("pattern RAM written outside the write state");

  a_tick_goes_to_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.func == lpps_pkg::FN_TICK)) |=> (state_r == S_TICK))
    else $error("tick transfer did not start the tick cycle");

  a_advance_restarts_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_TICK) && start_r) |-> (step_cnt_r == lpps_pkg::STEP_W'(1)))
    else $error("row advanced but step counter not restarted");

  a_no_div_by_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cfg_span_r != '0))
    else $error("division running with zero span");

  a_result_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    tick_commit |=> out_vld_r)
    else $error("completed tick left no result");

endmodule

// ===== tb/lpps_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the LED pattern PWM sequencer: follows command, register and result transfers,
// keeps its own pattern memory, counters and step limit, and checks every tick result in order.
// Depends on lpps_pkg and the lpps_in_if / lpps_out_if interfaces.

module lpps_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  lpps_in_if                              in_mon,
  lpps_out_if                             out_mon,
  input  logic                            cfg_wr_en,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              ticks_outstanding
);
  import lpps_pkg::*;

  // head of the chase and its fading tail; index 0 is the head
  localparam logic [3:0][LVL_W-1:0] FADE = {8'd2, 8'd6, 8'd30, 8'd100};

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              start;
    logic [ROW_W-1:0]  row;
  } tick_result_t;

  logic [LVL_W-1:0]  pattern_mem [ROWS][LEDS];
  logic [LVL_W-1:0]  lane_level [LEDS];
  logic [ROW_W-1:0]  cur_row;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_lim;
  logic [PWM_W-1:0]  pwm_cnt;
  logic              lim_from_sample;

  logic [PWM_W-1:0]  pwm_period;
  logic [STEP_W-1:0] init_lim;
  logic [STEP_W-1:0] lim_at_zero;
  logic [STEP_W-1:0] lim_slope;
  logic [STEP_W-1:0] lim_span;

  tick_result_t expected_ticks [$];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("t=%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : track
    tick_result_t      want;
    tick_result_t      got;
    logic [STEP_W-1:0] limit;
    logic [31:0]       drop;
    int                head;
    int                idx;
    if (!rst_n) begin
      mismatch_count  = 0;
      expected_ticks.delete();
      pwm_period      = PWM_W'(100);
      init_lim        = STEP_W'(1000);
      lim_at_zero     = STEP_W'(4000);
      lim_slope       = STEP_W'(3);
      lim_span        = STEP_W'(1);
      cur_row         = '0;
      step_cnt        = '0;
      step_lim        = '0;
      pwm_cnt         = '1;
      lim_from_sample = 1'b0;
      for (int c = 0; c < LEDS; c++) lane_level[c] = '0;
      // Power-up chase: the head climbs LEDs 1..15 on rows 4..18 with its tail below it,
      // bounces on rows 3 and 19, and runs back down on rows 20..31 and 0..2.
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < LEDS; c++) pattern_mem[r][c] = '0;
        if (r == 3) begin
          pattern_mem[r][0] = 8'd50;
          pattern_mem[r][1] = 8'd6;
          pattern_mem[r][2] = 8'd2;
        end else if (r == 19) begin
          pattern_mem[r][13] = 8'd2;
          pattern_mem[r][14] = 8'd6;
          pattern_mem[r][15] = 8'd50;
        end else if (r >= 4 && r <= 18) begin
          head = r - 3;
          for (int k = 0; k < 4; k++) begin
            idx = head - k;
            if (idx >= 0) pattern_mem[r][idx] = FADE[k];
          end
        end else begin
          head = (34 - r) % 32;
          for (int k = 0; k < 4; k++) begin
            idx = head + k;
            if (idx < LEDS) pattern_mem[r][idx] = FADE[k];
          end
        end
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PWM_PERIOD: pwm_period  = cfg_wdata[PWM_W-1:0];
          CFG_INIT_LIMIT: init_lim    = cfg_wdata;
          CFG_LIMIT_ZERO: lim_at_zero = cfg_wdata;
          CFG_SLOPE:      lim_slope   = cfg_wdata;
          CFG_SPAN:       lim_span    = cfg_wdata;
          default: ;
        endcase
      end

      // results first, so a result cannot be matched against a tick taken on the same edge
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.led_mask, out_mon.start_conversion, out_mon.row_index};
        if (expected_ticks.size() == 0) begin
          report_mismatch("result transfer with none expected, led_mask", got.mask, 0);
        end else begin
          want = expected_ticks.pop_front();
          if (got.mask !== want.mask) report_mismatch("led_mask", got.mask, want.mask);
          if (got.start !== want.start)
            report_mismatch("start_conversion", got.start, want.start);
          if (got.row !== want.row) report_mismatch("row_index", got.row, want.row);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        case (func_t'(in_mon.func))
          FN_SAMPLE: begin
            // a zero span leaves the limit and its source untouched
            if (lim_span != '0) begin
              drop = (32'(lim_slope) * 32'(in_mon.sample)) / 32'(lim_span);
              step_lim = (drop >= 32'(lim_at_zero)) ? '0 : lim_at_zero - drop[STEP_W-1:0];
              lim_from_sample = 1'b1;
            end
          end
          FN_WRITE: pattern_mem[in_mon.row][in_mon.led] = in_mon.level;
          FN_TICK: begin
            limit = lim_from_sample ? step_lim : init_lim;
            want.start = 1'b0;
            if (step_cnt >= limit) begin
              want.start = 1'b1;
              cur_row    = cur_row + 1'b1;
              step_cnt   = '0;
            end
            if (pwm_cnt >= pwm_period) begin
              for (int c = 0; c < LEDS; c++) lane_level[c] = pattern_mem[cur_row][c];
              pwm_cnt = '0;
            end
            want.mask = '0;
            for (int c = 0; c < LEDS; c++) begin
              if (lane_level[c] != '0) begin
                lane_level[c] = lane_level[c] - 1'b1;
                want.mask[c]  = 1'b1;
              end
            end
            step_cnt = step_cnt + 1'b1;
            pwm_cnt  = pwm_cnt + 1'b1;
            want.row = cur_row;
            expected_ticks.push_back(want);
          end
          default: ;
        endcase
      end
    end
    ticks_outstanding <= expected_ticks.size();
  end

endmodule

// ===== tb/tb_led_pattern_pwm_sequencer.sv =====
`timescale 1ns / 100ps
// Top of the LED pattern PWM sequencer testbench: clock, reset, register set-up per phase,
// command stimulus, result back-pressure and the final verdict from lpps_checker.
// Depends on lpps_pkg, lpps_ifs, the sequencer RTL and tb/lpps_checker.sv.

module tb_led_pattern_pwm_sequencer;
  import lpps_pkg::*;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 135;
  localparam int IDLE_PCT       = 38;
  localparam int QUIET_PHASE    = 2;
  localparam int PRESSURE_PHASE = 3;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;   // covers the divide of a sample
  localparam int RUN_LIMIT_NS   = 10_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  typedef struct packed {
    logic [PWM_W-1:0]  pwm;
    logic [STEP_W-1:0] init_lim;
    logic [STEP_W-1:0] zero_lim;
    logic [STEP_W-1:0] slope;
    logic [STEP_W-1:0] span;
  } reg_set_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    ticks_in_flight;
  bit                    no_idle;
  bit                    hold_req;

  lpps_in_if  in_ch ();
  lpps_out_if out_ch ();

  led_pattern_pwm_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lpps_checker tick_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatches),
    .ticks_outstanding (ticks_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("led_pattern_pwm_sequencer test failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none in the quiet phase.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done    = 1'b1;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic issue_command(input func_t f, input logic [SMP_W-1:0] smp,
                               input logic [ROW_W-1:0] r, input logic [LED_W-1:0] l,
                               input logic [LVL_W-1:0] lv);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.sample <= smp;
    in_ch.row    <= r;
    in_ch.led    <= l;
    in_ch.level  <= lv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // caller drops cfg_wr_en after the last write of a burst
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ticks_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    reg_set_t         s;
    func_t            f;
    logic [LVL_W-1:0] lv;
    int               roll;
    int               counted;
    rst_n        = 1'b0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FN_TICK;
    in_ch.sample = '0;
    in_ch.row    = '0;
    in_ch.led    = '0;
    in_ch.level  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes, all functions incl. the unused one
    issue_command(FN_TICK,   10'd0,    5'd0,  4'd0,  8'd0);
    issue_command(FN_TICK,   10'd0,    5'd0,  4'd0,  8'd0);
    issue_command(FN_NONE,   10'h3ff,  5'h1f, 4'hf,  8'hff);
    issue_command(FN_WRITE,  10'd0,    5'd0,  4'd0,  8'hff);
    issue_command(FN_WRITE,  10'h3ff,  5'h1f, 4'hf,  8'h00);
    issue_command(FN_WRITE,  10'd0,    5'd0,  4'hf,  8'd1);
    issue_command(FN_TICK,   10'h3ff,  5'h1f, 4'hf,  8'hff);
    issue_command(FN_SAMPLE, 10'd0,    5'd0,  4'd0,  8'd0);
    issue_command(FN_TICK,   10'd0,    5'd0,  4'd0,  8'd0);
    issue_command(FN_SAMPLE, 10'h3ff,  5'h1f, 4'hf,  8'hff);
    issue_command(FN_SAMPLE, 10'h155,  5'h0a, 4'h5,  8'h55);
    issue_command(FN_WRITE,  10'h2aa,  5'd0,  4'd7,  8'haa);
    issue_command(FN_WRITE,  10'h155,  5'd21, 4'd10, 8'h55);
    issue_command(FN_NONE,   10'd0,    5'd0,  4'd0,  8'd0);
    repeat (6) issue_command(FN_TICK, 10'd0, 5'd0, 4'd0, 8'd0);

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      case (p)
        0: s = '{8'd0, 16'd0, 16'd0, 16'd0, 16'd0};                 // lows, zero span
        1: s = '{8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};    // highs
        2: s = '{8'd7, 16'd3, 16'd40, 16'd1, 16'd32};
        3: s = '{8'd20, 16'd10, 16'd30, 16'd100, 16'd7};            // limit clamps at zero
        4: s = '{8'd3, 16'd5, 16'd12, 16'd1, 16'd100};
        default: begin
          s.pwm      = PWM_W'($urandom_range(0, 30));
          s.init_lim = STEP_W'($urandom_range(0, 30));
          s.zero_lim = STEP_W'($urandom_range(0, 64));
          s.slope    = STEP_W'($urandom_range(0, 8));
          s.span     = ($urandom_range(0, 3) == 0) ? '0 : STEP_W'($urandom_range(1, 64));
        end
      endcase
      // junk in the upper byte of the period write must be dropped
      write_reg(CFG_PWM_PERIOD, {8'($urandom), s.pwm});
      write_reg(CFG_INIT_LIMIT, s.init_lim);
      write_reg(CFG_LIMIT_ZERO, s.zero_lim);
      write_reg(CFG_SLOPE, s.slope);
      write_reg(CFG_SPAN, s.span);
      write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
      cfg_wr_en <= 1'b0;

      no_idle = (p == QUIET_PHASE);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 58)      f = FN_TICK;
        else if (roll < 73) f = FN_SAMPLE;
        else if (roll < 95) f = FN_WRITE;
        else                f = FN_NONE;
        if ($urandom_range(0, 1) == 0) lv = LVL_W'($urandom);
        else                           lv = LVL_W'($urandom_range(0, 12));
        if (p == PRESSURE_PHASE && counted == 30) hold_req = 1'b1;
        issue_command(f, SMP_W'($urandom), ROW_W'($urandom), LED_W'($urandom), lv);
        if (f != FN_NONE) counted++;
      end
      no_idle = 1'b0;
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("led_pattern_pwm_sequencer test passed");
    end else begin
      $display("led_pattern_pwm_sequencer test failed");
    end
    $finish;
  end

endmodule
